FILE: rtl/pct_pkg.sv
// Package for the prescaled cascade timer: payload types, codes and divisor table.
`timescale 1ns / 1ps
package pct_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		REQ_READ    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_SYSTICK = 2'd2,
		REQ_CASCADE = 2'd3
	} req_kind_t;

	// Byte addresses of the register file
	localparam logic [1:0] ADDR_CNT_LO = 2'd0;
	localparam logic [1:0] ADDR_CNT_HI = 2'd1;
	localparam logic [1:0] ADDR_CTL_LO = 2'd2;
	localparam logic [1:0] ADDR_CTL_HI = 2'd3;

	// Configuration register indexes
	localparam logic CFG_TIMER_INDEX = 1'b0;

	// Control word bit positions
	localparam int CTL_SEL_LSB   = 0;
	localparam int CTL_CASCADE_B = 2;
	localparam int CTL_IRQ_EN_B  = 6;
	localparam int CTL_START_B   = 7;

	// Prescaler divisors
	localparam int DIV_W = 11;
	localparam logic [DIV_W-1:0] PRESCALE_SEL1 = 11'd64;
	localparam logic [DIV_W-1:0] PRESCALE_SEL2 = 11'd256;
	localparam logic [DIV_W-1:0] PRESCALE_SEL3 = 11'd1024;

	typedef struct packed {
		req_kind_t  req_type;
		logic [1:0] reg_addr;
		logic [7:0] write_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       overflowed;
		logic       irq_request;
	} out_item_t;

	// Map the two select bits to the prescaler divisor
	function automatic logic [DIV_W-1:0] divisor_for(input logic [1:0] sel);
		logic [DIV_W-1:0] d;
		case (sel)
			2'd1:    d = PRESCALE_SEL1;
			2'd2:    d = PRESCALE_SEL2;
			2'd3:    d = PRESCALE_SEL3;
			default: d = 11'd1;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/prescaled_cascade_timer.sv
// Top level of the prescaled cascade timer: register file, counter, prescaler and result buffer.
//
//  channel  | direction | handshake          | payload
//  in       | input     | in_valid/in_ready   | in_data  (in_item_t)
//  out      | output    | out_valid/out_ready | out_data (out_item_t)
//  cfg      | input     | APB psel/penable    | pwdata[1:0] timer index at byte 0
//
// Each item is decoded and applied to the timer state in the cycle it is accepted; its result
// is registered in the output register (skid register if stalled), one item per clock unless stalled.
// A skid register behind the output register keeps input accepted for one extra
// item while the output is stalled; in_ready falls only when both are full.
// Reset clears all timer state, the timer index and both result slots.
`timescale 1ns / 1ps
module prescaled_cascade_timer import pct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]       timer_index_q;
	logic [15:0]      count_q;
	logic [15:0]      reload_q;
	logic [15:0]      control_q;
	logic [9:0]       prescale_q;

	out_item_t        out_q;
	logic             out_valid_q;
	out_item_t        skid_q;
	logic             skid_valid_q;

	logic             in_fire;
	logic             out_fire;
	logic             running;
	logic             cascade;
	logic             tick;
	logic             wrap;
	logic [16:0]      count_inc;
	logic [DIV_W-1:0] pre_next;
	logic [15:0]      count_d;
	logic [15:0]      reload_d;
	logic [15:0]      control_d;
	logic [9:0]       prescale_d;
	out_item_t        res;

	assign pready    = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration register write and read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_index_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_TIMER_INDEX) begin
			timer_index_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == CFG_TIMER_INDEX) ? {30'd0, timer_index_q} : 32'd0;

	// Decode the item and work out next state and result
	assign running   = control_q[CTL_START_B];
	assign cascade   = control_q[CTL_CASCADE_B] && (timer_index_q != 2'd0);
	assign count_inc = {1'b0, count_q} + 17'd1;
	assign pre_next  = {1'b0, prescale_q} + 11'd1;

	always_comb begin
		count_d    = count_q;
		reload_d   = reload_q;
		control_d  = control_q;
		prescale_d = prescale_q;
		tick       = 1'b0;
		res        = '0;
		unique case (in_data.req_type)
			REQ_READ: begin
				unique case (in_data.reg_addr)
					ADDR_CNT_LO: res.read_byte = count_q[7:0];
					ADDR_CNT_HI: res.read_byte = count_q[15:8];
					ADDR_CTL_LO: res.read_byte = control_q[7:0];
					default:     res.read_byte = control_q[15:8];
				endcase
			end
			REQ_WRITE: begin
				unique case (in_data.reg_addr)
					ADDR_CNT_LO: reload_d[7:0]  = in_data.write_byte;
					ADDR_CNT_HI: reload_d[15:8] = in_data.write_byte;
					ADDR_CTL_LO: control_d[7:0] = in_data.write_byte;
					default:     control_d[15:8] = in_data.write_byte;
				endcase
				// Load the counter on a rising start bit
				if (!running && control_d[CTL_START_B]) begin
					count_d    = reload_q;
					prescale_d = '0;
				end
			end
			REQ_SYSTICK: begin
				if (running && !cascade) begin
					if (pre_next >= divisor_for(control_q[CTL_SEL_LSB +: 2])) begin
						prescale_d = '0;
						tick       = 1'b1;
					end else begin
						prescale_d = pre_next[9:0];
					end
				end
			end
			default: begin
				tick = running && cascade;
			end
		endcase
		// Advance the counter, reload on wrap
		wrap = tick && count_inc[16];
		if (tick) begin
			count_d = count_inc[16] ? reload_q : count_inc[15:0];
		end
		res.overflowed  = wrap;
		res.irq_request = wrap && control_q[CTL_IRQ_EN_B];
	end

	// Timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reload_q   <= '0;
			control_q  <= '0;
			prescale_q <= '0;
		end else if (in_fire) begin
			count_q    <= count_d;
			reload_q   <= reload_d;
			control_q  <= control_d;
			prescale_q <= prescale_d;
		end
	end

	// Result register with skid slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	// Skid slot only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full while output register empty");

	// Rising start bit loads the counter from reload
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.req_type == REQ_WRITE && in_data.reg_addr == ADDR_CTL_LO
		 && !running && in_data.write_byte[CTL_START_B])
		|=> (count_q == $past(reload_q) && prescale_q == '0))
		else $error("counter not loaded on start");

	// A stopped timer never counts
	a_stopped_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !running && in_data.req_type != REQ_WRITE) |=> $stable(count_q))
		else $error("counter moved while stopped");

	// Interrupt request only with an overflow, and never alongside read data
	a_irq_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!out_q.irq_request || out_q.overflowed)
		                 && (out_q.read_byte == 8'd0 || !out_q.overflowed)))
		else $error("inconsistent result flags");

endmodule
